[rtl/packet_protocol_classifier_defines.svh]
// Assertion macros used by the classifier top level.
`ifndef PACKET_PROTOCOL_CLASSIFIER_DEFINES_SVH
`define PACKET_PROTOCOL_CLASSIFIER_DEFINES_SVH

`ifndef ASSERT_OFF
`define PPC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define PPC_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define PPC_ASSERT(label, prop, msg)
`define PPC_NEVER(label, cond, msg)
`endif

`endif

[rtl/ppc_pkg.sv]
// Package with the types, constants and header offsets of the frame classifier.
package ppc_pkg;

    localparam int MAX_FRAME_BYTES = 2048;
    localparam int OFFSET_W = $clog2(MAX_FRAME_BYTES);
    localparam int POS_W = (OFFSET_W > 7) ? OFFSET_W : 7;

    localparam logic [OFFSET_W-1:0] OFFSET_LIMIT = OFFSET_W'(MAX_FRAME_BYTES - 1);

    localparam logic [OFFSET_W-1:0] OFF_ETH_TYPE_HI = OFFSET_W'(12);
    localparam logic [OFFSET_W-1:0] OFF_ETH_TYPE_LO = OFFSET_W'(13);
    localparam logic [OFFSET_W-1:0] OFF_IP_IHL = OFFSET_W'(14);
    localparam logic [OFFSET_W-1:0] OFF_IP_PROTO = OFFSET_W'(23);
    localparam logic [POS_W-1:0] IP_HEADER_START = POS_W'(14);

    localparam logic [15:0] ETH_TYPE_IPV4 = 16'h0800;
    localparam logic [7:0] PROTO_ICMP = 8'd1;
    localparam logic [7:0] PROTO_TCP = 8'd6;
    localparam logic [7:0] PROTO_UDP = 8'd17;
    localparam logic [15:0] DNS_PORT_RESET = 16'd53;

    localparam int ADDR_W = 3;
    localparam logic REG_DNS_PORT = 1'b0;

    typedef enum logic [2:0] {
        CLASS_NON_IP = 3'd0,
        CLASS_ICMP = 3'd1,
        CLASS_TCP = 3'd2,
        CLASS_TCP_DNS = 3'd3,
        CLASS_UDP = 3'd4,
        CLASS_UDP_DNS = 3'd5,
        CLASS_OTHER_IP = 3'd6
    } frame_class_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic last;
    } byte_item_t;

    typedef struct packed {
        frame_class_t frame_class;
        logic [31:0] udp_total;
        logic [31:0] udp_dns_total;
    } result_t;

endpackage

[rtl/ppc_apb_regs.sv]
// APB register file holding the DNS port number.
module ppc_apb_regs (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [ppc_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    output logic [15:0]                 dns_port
);
    import ppc_pkg::*;

    logic [15:0] dns_port_reg;
    logic [15:0] dns_port_next;

    always_comb
    begin
        dns_port_next = dns_port_reg;
        if (psel && penable && pwrite && (paddr[ADDR_W-1] == REG_DNS_PORT))
        begin
            dns_port_next = pwdata[15:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dns_port_reg <= DNS_PORT_RESET;
        end
        else
        begin
            dns_port_reg <= dns_port_next;
        end
    end

    assign prdata = (paddr[ADDR_W-1] == REG_DNS_PORT) ? {16'd0, dns_port_reg} : 32'd0;
    assign pready = 1'b1;
    assign dns_port = dns_port_reg;

endmodule

[rtl/ppc_frame_parser.sv]
// Per-frame header capture, classification and UDP counters.
module ppc_frame_parser (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                fire,
    input  ppc_pkg::byte_item_t item,
    input  logic [15:0]         dns_port,
    output logic                res_valid,
    output ppc_pkg::result_t    res
);
    import ppc_pkg::*;

    logic [OFFSET_W-1:0] offset_reg, offset_next;
    logic [15:0]         ether_type_reg, ether_type_next;
    logic [7:0]          ip_protocol_reg, ip_protocol_next;
    logic [3:0]          ip_header_words_reg, ip_header_words_next;
    logic [15:0]         source_port_reg, source_port_next;
    logic [15:0]         dest_port_reg, dest_port_next;
    logic [31:0]         udp_count_reg, udp_count_next;
    logic [31:0]         udp_dns_count_reg, udp_dns_count_next;

    logic [15:0]         ether_type_upd;
    logic [7:0]          ip_protocol_upd;
    logic [3:0]          ip_header_words_upd;
    logic [15:0]         source_port_upd;
    logic [15:0]         dest_port_upd;
    logic [31:0]         udp_count_upd;
    logic [31:0]         udp_dns_count_upd;
    logic                active;
    logic [POS_W-1:0]    pos;
    logic [POS_W-1:0]    tstart;
    logic [POS_W-1:0]    tend;
    logic                ports_ok;
    logic                dns;
    frame_class_t        cls;

    always_comb
    begin
        active = (offset_reg < OFFSET_LIMIT);
        pos = POS_W'(offset_reg);
        ether_type_upd = ether_type_reg;
        ip_protocol_upd = ip_protocol_reg;
        ip_header_words_upd = ip_header_words_reg;
        source_port_upd = source_port_reg;
        dest_port_upd = dest_port_reg;

        if (active)
        begin
            if (offset_reg == OFF_ETH_TYPE_HI)
            begin
                ether_type_upd[15:8] = item.data_byte;
            end
            if (offset_reg == OFF_ETH_TYPE_LO)
            begin
                ether_type_upd[7:0] = item.data_byte;
            end
            if (offset_reg == OFF_IP_IHL)
            begin
                ip_header_words_upd = item.data_byte[3:0];
            end
            if (offset_reg == OFF_IP_PROTO)
            begin
                ip_protocol_upd = item.data_byte;
            end
        end

        // The transport header starts after the IPv4 header, using the length seen so far.
        tstart = IP_HEADER_START + POS_W'({ip_header_words_upd, 2'b00});
        tend = tstart + POS_W'(3);

        if (active)
        begin
            if (pos == tstart)
            begin
                source_port_upd[15:8] = item.data_byte;
            end
            if (pos == tstart + POS_W'(1))
            begin
                source_port_upd[7:0] = item.data_byte;
            end
            if (pos == tstart + POS_W'(2))
            begin
                dest_port_upd[15:8] = item.data_byte;
            end
            if (pos == tend)
            begin
                dest_port_upd[7:0] = item.data_byte;
            end
        end

        ports_ok = (tend < POS_W'(OFFSET_LIMIT)) && (pos >= tend);
        dns = ports_ok && ((source_port_upd == dns_port) || (dest_port_upd == dns_port));

        udp_count_upd = udp_count_reg;
        udp_dns_count_upd = udp_dns_count_reg;
        if ((offset_reg < OFF_ETH_TYPE_LO) || (ether_type_upd != ETH_TYPE_IPV4))
        begin
            cls = CLASS_NON_IP;
        end
        else if (ip_protocol_upd == PROTO_ICMP)
        begin
            cls = CLASS_ICMP;
        end
        else if (ip_protocol_upd == PROTO_TCP)
        begin
            cls = dns ? CLASS_TCP_DNS : CLASS_TCP;
        end
        else if (ip_protocol_upd == PROTO_UDP)
        begin
            cls = dns ? CLASS_UDP_DNS : CLASS_UDP;
            udp_count_upd = udp_count_reg + 32'd1;
            if (dns)
            begin
                udp_dns_count_upd = udp_dns_count_reg + 32'd1;
            end
        end
        else
        begin
            cls = CLASS_OTHER_IP;
        end

        offset_next = offset_reg;
        ether_type_next = ether_type_reg;
        ip_protocol_next = ip_protocol_reg;
        ip_header_words_next = ip_header_words_reg;
        source_port_next = source_port_reg;
        dest_port_next = dest_port_reg;
        udp_count_next = udp_count_reg;
        udp_dns_count_next = udp_dns_count_reg;

        if (fire)
        begin
            if (item.last)
            begin
                offset_next = '0;
                ether_type_next = '0;
                ip_protocol_next = '0;
                ip_header_words_next = '0;
                source_port_next = '0;
                dest_port_next = '0;
                udp_count_next = udp_count_upd;
                udp_dns_count_next = udp_dns_count_upd;
            end
            else
            begin
                offset_next = active ? (offset_reg + OFFSET_W'(1)) : offset_reg;
                ether_type_next = ether_type_upd;
                ip_protocol_next = ip_protocol_upd;
                ip_header_words_next = ip_header_words_upd;
                source_port_next = source_port_upd;
                dest_port_next = dest_port_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg <= '0;
            ether_type_reg <= '0;
            ip_protocol_reg <= '0;
            ip_header_words_reg <= '0;
            source_port_reg <= '0;
            dest_port_reg <= '0;
            udp_count_reg <= '0;
            udp_dns_count_reg <= '0;
        end
        else
        begin
            offset_reg <= offset_next;
            ether_type_reg <= ether_type_next;
            ip_protocol_reg <= ip_protocol_next;
            ip_header_words_reg <= ip_header_words_next;
            source_port_reg <= source_port_next;
            dest_port_reg <= dest_port_next;
            udp_count_reg <= udp_count_next;
            udp_dns_count_reg <= udp_dns_count_next;
        end
    end

    assign res_valid = fire && item.last;
    assign res.frame_class = cls;
    assign res.udp_total = udp_count_upd;
    assign res.udp_dns_total = udp_dns_count_upd;

endmodule

[rtl/packet_protocol_classifier.sv]
// Top level of the Ethernet/IPv4 frame classifier.
//
//   Channel   Handshake                     Payload
//   input     in_valid / in_ready           data_byte, last
//   output    out_valid / out_ready         frame_class, udp_total, udp_dns_total
//   config    psel, penable, pwrite, pready paddr, pwdata, prdata
//
// An accepted item is held in the input register, and for a final byte the header logic writes
// the frame's result into the result register, which drives out_valid.
// One item is accepted every cycle, unless a final byte waits while the result register is full and not taken.
// Reset clears the frame state, the counters and both valid flags, and sets the DNS port to 53.
// A stalled output holds the result; in_ready drops only while a final byte waits behind it.
`include "packet_protocol_classifier_defines.svh"

module packet_protocol_classifier (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [7:0]                  data_byte,
    input  logic                        last,
    output logic                        out_valid,
    input  logic                        out_ready,
    output ppc_pkg::frame_class_t       frame_class,
    output logic [31:0]                 udp_total,
    output logic [31:0]                 udp_dns_total,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [ppc_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import ppc_pkg::*;

    logic       item_valid_reg, item_valid_next;
    byte_item_t item_reg;
    logic       out_valid_reg, out_valid_next;
    result_t    out_reg;
    logic       parse_fire;
    logic       res_valid;
    result_t    res;
    logic [15:0] dns_port;

    ppc_apb_regs u_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .dns_port (dns_port)
    );

    ppc_frame_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (parse_fire),
        .item      (item_reg),
        .dns_port  (dns_port),
        .res_valid (res_valid),
        .res       (res)
    );

    assign parse_fire = item_valid_reg && (!item_reg.last || !out_valid_reg || out_ready);
    assign in_ready = !item_valid_reg || parse_fire;

    always_comb
    begin
        item_valid_next = item_valid_reg;
        if (in_valid && in_ready)
        begin
            item_valid_next = 1'b1;
        end
        else if (parse_fire)
        begin
            item_valid_next = 1'b0;
        end
        out_valid_next = res_valid || (out_valid_reg && !out_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            item_valid_reg <= item_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg.data_byte <= data_byte;
            item_reg.last <= last;
        end
        if (res_valid)
        begin
            out_reg <= res;
        end
    end

    assign out_valid = out_valid_reg;
    assign frame_class = out_reg.frame_class;
    assign udp_total = out_reg.udp_total;
    assign udp_dns_total = out_reg.udp_dns_total;

    `PPC_NEVER(a_no_result_overwrite, res_valid && out_valid_reg && !out_ready, "result lost")
    `PPC_ASSERT(a_accept_loads_item, in_valid && in_ready |=> item_valid_reg, "item not held")
    `PPC_ASSERT(a_stalled_item_kept, item_valid_reg && !parse_fire |=> item_valid_reg, "item dropped")

endmodule

[verif/ppc_checker.sv]
// Checker for the frame classifier: predicts the class and totals of every frame and compares.
`timescale 1ns / 100ps

module ppc_checker (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic                       in_ready,
    input  logic [7:0]                 data_byte,
    input  logic                       last,
    input  logic                       out_valid,
    input  logic                       out_ready,
    input  ppc_pkg::frame_class_t      frame_class,
    input  logic [31:0]                udp_total,
    input  logic [31:0]                udp_dns_total,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [ppc_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    input  logic                       pready,
    output int                         mismatch_count,
    output int                         results_pending,
    output int                         results_checked
);
    import ppc_pkg::*;

    result_t             expected_results[$];
    logic [OFFSET_W-1:0] frame_offset;
    logic [15:0]         eth_type;
    logic [7:0]          l4_proto;
    logic [3:0]          hdr_words;
    logic [15:0]         sport_seen;
    logic [15:0]         dport_seen;
    logic [31:0]         udp_seen;
    logic [31:0]         udp_dns_seen;
    logic [15:0]         dns_match_port;
    int                  mismatches;
    int                  checked;

    task automatic clear_frame_state();
        frame_offset = '0;
        eth_type = '0;
        l4_proto = '0;
        hdr_words = '0;
        sport_seen = '0;
        dport_seen = '0;
    endtask

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
        end
    endfunction

    task automatic classify_byte(input logic [7:0] value, input logic is_last);
        int      off;
        int      port_pos;
        bit      ports_seen;
        bit      dns_hit;
        result_t res;
        off = frame_offset;
        if (off < OFFSET_LIMIT)
        begin
            if (off == OFF_ETH_TYPE_HI)
                eth_type[15:8] = value;
            else if (off == OFF_ETH_TYPE_LO)
                eth_type[7:0] = value;
            else if (off == OFF_IP_IHL)
                hdr_words = value[3:0];
            else if (off == OFF_IP_PROTO)
                l4_proto = value;

            port_pos = int'(IP_HEADER_START) + 4 * hdr_words;
            if (off == port_pos)
                sport_seen[15:8] = value;
            else if (off == port_pos + 1)
                sport_seen[7:0] = value;
            else if (off == port_pos + 2)
                dport_seen[15:8] = value;
            else if (off == port_pos + 3)
                dport_seen[7:0] = value;
            frame_offset = OFFSET_W'(off + 1);
        end

        if (is_last)
        begin
            port_pos = int'(IP_HEADER_START) + 4 * hdr_words;
            ports_seen = (port_pos + 3 < OFFSET_LIMIT) && (off >= port_pos + 3);
            dns_hit = ports_seen && (sport_seen == dns_match_port || dport_seen == dns_match_port);
            if (off < OFF_ETH_TYPE_LO || eth_type != ETH_TYPE_IPV4)
                res.frame_class = CLASS_NON_IP;
            else if (l4_proto == PROTO_ICMP)
                res.frame_class = CLASS_ICMP;
            else if (l4_proto == PROTO_TCP)
                res.frame_class = dns_hit ? CLASS_TCP_DNS : CLASS_TCP;
            else if (l4_proto == PROTO_UDP)
            begin
                udp_seen++;
                if (dns_hit)
                    udp_dns_seen++;
                res.frame_class = dns_hit ? CLASS_UDP_DNS : CLASS_UDP;
            end
            else
                res.frame_class = CLASS_OTHER_IP;
            res.udp_total = udp_seen;
            res.udp_dns_total = udp_dns_seen;
            expected_results.push_back(res);
            clear_frame_state();
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
        begin
            clear_frame_state();
            udp_seen = '0;
            udp_dns_seen = '0;
            dns_match_port = DNS_PORT_RESET;
            expected_results.delete();
            mismatches = 0;
            checked = 0;
            mismatch_count <= 0;
            results_pending <= 0;
            results_checked <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: result with none expected, expected nothing, got class %0d",
                             $time, frame_class);
                end
                else
                begin
                    want = expected_results.pop_front();
                    checked++;
                    check_field("frame_class", 32'(want.frame_class), 32'(frame_class));
                    check_field("udp_total", want.udp_total, udp_total);
                    check_field("udp_dns_total", want.udp_dns_total, udp_dns_total);
                end
            end
            if (psel && penable && pwrite && pready && paddr[ADDR_W-1:2] == REG_DNS_PORT)
                dns_match_port = pwdata[15:0];
            if (in_valid && in_ready)
                classify_byte(data_byte, last);
            mismatch_count <= mismatches;
            results_pending <= expected_results.size();
            results_checked <= checked;
        end
    end

endmodule

[verif/testbench.sv]
// Top of the frame classifier testbench: clock, reset, frame stimulus, register writes and verdict.
`timescale 1ns / 100ps

module testbench;
    import ppc_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int HOLD_CYCLES = 300;
    localparam int PHASE_BYTES = 180;
    localparam logic [ADDR_W-1:0] DNS_PORT_ADDR = ADDR_W'(REG_DNS_PORT) << 2;
    localparam logic [ADDR_W-1:0] SPARE_ADDR = ADDR_W'(1) << 2;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_ready;
    logic [7:0]        data_byte = 8'h00;
    logic              last = 1'b0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    frame_class_t      frame_class;
    logic [31:0]       udp_total;
    logic [31:0]       udp_dns_total;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [31:0]       pwdata = '0;
    logic [31:0]       prdata;
    logic              pready;

    int          mismatch_count;
    int          results_pending;
    int          results_checked;
    int          cycle_count = 0;
    int          burst_left = 0;
    int          bytes_sent = 0;
    int          frames_sent = 0;
    bit          hold_request = 1'b0;
    logic [15:0] dns_setting = DNS_PORT_RESET;
    logic [7:0]  frame_bytes[$];

    packet_protocol_classifier uut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .data_byte(data_byte),
        .last(last),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .frame_class(frame_class),
        .udp_total(udp_total),
        .udp_dns_total(udp_dns_total),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    ppc_checker u_checker (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .data_byte(data_byte),
        .last(last),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .frame_class(frame_class),
        .udp_total(udp_total),
        .udp_dns_total(udp_dns_total),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .pready(pready),
        .mismatch_count(mismatch_count),
        .results_pending(results_pending),
        .results_checked(results_checked)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin : receiver
        int span;
        int style;
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            style = $urandom_range(0, 3);
            span = $urandom_range(5, 60);
            repeat (span)
            begin
                if (hold_request)
                begin
                    out_ready <= 1'b0;
                    repeat (HOLD_CYCLES) @(posedge clk);
                    hold_request = 1'b0;
                end
                case (style)
                    0: out_ready <= 1'b1;
                    1: out_ready <= 1'($urandom_range(0, 1));
                    2: out_ready <= ($urandom_range(0, 5) == 0);
                    default: out_ready <= ~out_ready;
                endcase
                @(posedge clk);
            end
        end
    end

    task automatic send_byte(input logic [7:0] value, input logic is_last);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 200)
                                                     : $urandom_range(1, 12);
        end
        burst_left--;
        in_valid <= 1'b1;
        data_byte <= value;
        last <= is_last;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        bytes_sent++;
    endtask

    task automatic send_frame();
        foreach (frame_bytes[i])
            send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
        frames_sent++;
    endtask

    task automatic build_frame(input logic [15:0] etype, input logic [3:0] words,
                               input logic [7:0] proto, input logic [15:0] sport,
                               input logic [15:0] dport, input int len);
        int          pos;
        logic [31:0] ports;
        frame_bytes.delete();
        repeat (len) frame_bytes.push_back(8'($urandom));
        pos = int'(IP_HEADER_START) + 4 * words;
        ports = {sport, dport};
        for (int i = 0; i < 4; i++)
            if (pos + i < len)
                frame_bytes[pos + i] = ports[31 - 8 * i -: 8];
        if (OFF_IP_PROTO < len)
            frame_bytes[OFF_IP_PROTO] = proto;
        if (OFF_IP_IHL < len)
            frame_bytes[OFF_IP_IHL] = {4'($urandom), words};
        if (OFF_ETH_TYPE_HI < len)
            frame_bytes[OFF_ETH_TYPE_HI] = etype[15:8];
        if (OFF_ETH_TYPE_LO < len)
            frame_bytes[OFF_ETH_TYPE_LO] = etype[7:0];
    endtask

    function automatic logic [15:0] pick_port();
        return ($urandom_range(0, 2) == 0) ? dns_setting : 16'($urandom);
    endfunction

    task automatic send_random_frame();
        int         r;
        int         len;
        int         words;
        logic [7:0] proto;
        r = $urandom_range(0, 99);
        words = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : 5;
        case ($urandom_range(0, 4))
            0: proto = PROTO_ICMP;
            1: proto = PROTO_TCP;
            2, 3: proto = PROTO_UDP;
            default: proto = 8'($urandom);
        endcase
        len = 14 + 4 * words + 4;
        if (len < 24)
            len = 24;
        len = len + $urandom_range(0, 16);
        if (r < 10)
            len = $urandom_range(1, 14 + 4 * words + 3);
        build_frame((r >= 10 && r < 18) ? 16'($urandom) : ETH_TYPE_IPV4, 4'(words), proto,
                    pick_port(), pick_port(), len);
        if (r >= 92)
            foreach (frame_bytes[i])
                frame_bytes[i] = 8'($urandom);
        send_frame();
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (results_pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic reg_write(input logic [ADDR_W-1:0] addr, input logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    initial
    begin
        logic [31:0] settings[5];
        int          phase_start;
        settings = '{32'h5A5A_0035, 32'h0000_0000, 32'h0000_FFFF, $urandom, $urandom};

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        build_frame(ETH_TYPE_IPV4, 5, PROTO_UDP, 16'd53, 16'd53, 1);
        send_frame();
        build_frame(ETH_TYPE_IPV4, 5, PROTO_UDP, 16'd53, 16'd53, 13);
        send_frame();
        build_frame(ETH_TYPE_IPV4, 5, PROTO_UDP, 16'd53, 16'd53, 14);
        send_frame();
        build_frame(ETH_TYPE_IPV4, 5, PROTO_UDP, 16'd53, 16'd53, 23);
        send_frame();
        build_frame(ETH_TYPE_IPV4, 5, PROTO_ICMP, 16'd53, 16'd80, 42);
        send_frame();
        build_frame(ETH_TYPE_IPV4, 5, PROTO_TCP, 16'd1024, 16'd80, 60);
        send_frame();
        build_frame(ETH_TYPE_IPV4, 5, PROTO_TCP, 16'd53, 16'd4000, 60);
        send_frame();
        build_frame(ETH_TYPE_IPV4, 5, PROTO_TCP, 16'd4000, 16'd53, 60);
        send_frame();
        build_frame(ETH_TYPE_IPV4, 5, PROTO_UDP, 16'd5000, 16'd6000, 42);
        send_frame();
        build_frame(ETH_TYPE_IPV4, 5, PROTO_UDP, 16'd53, 16'd6000, 42);
        send_frame();
        build_frame(ETH_TYPE_IPV4, 5, PROTO_UDP, 16'd5000, 16'd53, 42);
        send_frame();
        build_frame(ETH_TYPE_IPV4, 5, PROTO_UDP, 16'd5000, 16'd53, 37);
        send_frame();
        build_frame(ETH_TYPE_IPV4, 0, PROTO_UDP, 16'h0053, 16'd53, 30);
        send_frame();
        build_frame(ETH_TYPE_IPV4, 15, PROTO_UDP, 16'd7, 16'd53, 80);
        send_frame();
        build_frame(ETH_TYPE_IPV4, 2, PROTO_UDP, 16'd53, 16'd53, 30);
        send_frame();
        build_frame(ETH_TYPE_IPV4, 5, 8'hFF, 16'd53, 16'd53, 42);
        send_frame();
        build_frame(16'h86DD, 5, PROTO_UDP, 16'd53, 16'd53, 42);
        send_frame();
        frame_bytes.delete();
        repeat (40) frame_bytes.push_back(8'h00);
        send_frame();
        frame_bytes.delete();
        repeat (40) frame_bytes.push_back(8'hFF);
        send_frame();

        for (int p = 0; p < 5; p++)
        begin
            wait_idle();
            reg_write(DNS_PORT_ADDR, settings[p]);
            dns_setting = settings[p][15:0];
            if (p == 3)
                reg_write(SPARE_ADDR, $urandom);
            phase_start = bytes_sent;
            if (p == 1)
            begin
                hold_request = 1'b1;
                repeat (40)
                begin
                    build_frame(ETH_TYPE_IPV4, 5, PROTO_UDP, dns_setting, dns_setting,
                                $urandom_range(1, 4));
                    send_frame();
                end
            end
            while (bytes_sent - phase_start < PHASE_BYTES)
                send_random_frame();
        end

        wait_idle();
        repeat (8) @(posedge clk);
        $display("Sent %0d frames (%0d bytes) under six DNS port settings, checked %0d results,",
                 frames_sent, bytes_sent, results_checked);
        $display("including truncated, noise, odd header length and long output stall frames.");
        if (mismatch_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

[filelist.f]
+incdir+rtl
rtl/ppc_pkg.sv
rtl/ppc_apb_regs.sv
rtl/ppc_frame_parser.sv
rtl/packet_protocol_classifier.sv
verif/ppc_checker.sv
verif/testbench.sv
